[hdl/tmh_pkg.sv]
// Types, codes and constants shared by the timer heap scheduler.
// No dependencies.
`default_nettype none
package tmh_pkg;
  localparam int NUM_TIMERS = 32;
  localparam int ID_W       = 5;
  localparam int TIME_W     = 48;
  localparam int PER_W      = 32;
  localparam int HEAP_AW    = 6;
  localparam int CNT_W      = 6;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_ADV   = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_STP_RD, S_STP_CMP, S_SU_RD, S_SU_CMP, S_SD_RD, S_SD_CMP,
    S_ADV_RD, S_ADV_SLOT, S_ADV_EVAL, S_ADV_DIV, S_FLUSH
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] exp;
    logic [ID_W-1:0]   slot;
  } heap_entry_t;

  typedef struct packed {
    logic              catch_up;
    logic [PER_W-1:0]  period;
  } slot_cfg_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction
endpackage
`default_nettype wire

[hdl/timer_min_heap_scheduler.sv]
// Timer scheduler over a binary min-heap held in a two-read-port memory.
// Start and stop walk the heap one level at a time; an advance re-sifts the heap
// for each due timer, and a catch-up remainder first runs through the serial
// remainder unit.
// One item at a time; the heap walk sets the rate. Reset clears the fill count,
// the slot position table and the time; the heap memory needs no clearing.
`default_nettype none
module timer_min_heap_scheduler
  import tmh_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // timer_id[4:0], now_tick[52:5], delay_ticks[84:53], period_ticks[116:85],
  // catch_up[117], zero[119:118]
  input  wire logic [119:0] in_tdata,
  // req_type[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // fired_id[4:0], status[6:5], zero[7]
  output logic [7:0]        out_tdata,
  // fired[0]
  output logic              out_tuser,
  output logic              out_tlast
);
  state_t            state_r, state_nxt;
  req_t              op_r, op_nxt;
  logic [TIME_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HEAP_AW-1:0] k_r, k_nxt;
  heap_entry_t       ent_r, ent_nxt;
  heap_entry_t       top_r, top_nxt;
  logic [PER_W-1:0]  per_r, per_nxt;
  logic [HEAP_AW-1:0] pos_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] seen_r;

  heap_entry_t       heap_mem [0:NUM_TIMERS];
  logic              re;
  logic [HEAP_AW-1:0] ra_addr, rb_addr, waddr;
  heap_entry_t       ra_data_r, rb_data_r, wdata;
  logic              we;

  slot_cfg_t         pm_mem [NUM_TIMERS];
  logic              pm_we, pm_re;
  logic [ID_W-1:0]   pm_wa, pm_ra;
  slot_cfg_t         pm_wd, pm_rd_r;

  logic              pos_we;
  logic [ID_W-1:0]   pos_idx;
  logic [HEAP_AW-1:0] pos_val;
  logic              seen_clr, seen_set;

  logic              hold_v_r, hold_fired_r, out_v_r, out_fired_r, out_last_r;
  logic [ID_W-1:0]   hold_id_r, out_id_r, push_id;
  status_t           hold_st_r, out_st_r, push_st;
  logic              push, push_fired, out_free, can_push, move;

  logic              div_start, div_done;
  logic [TIME_W-1:0] div_dvd;
  logic [PER_W-1:0]  div_rem;

  req_t              in_req;
  logic [ID_W-1:0]   in_id;
  logic [TIME_W-1:0] in_now;
  logic [PER_W-1:0]  in_delay, in_period;
  logic              in_catch, in_fire;

  logic [HEAP_AW:0]  c_w, c1_w;
  logic              use_b, again;
  heap_entry_t       ch;
  logic [TIME_W-1:0] at1, pad;
  state_t            ret_state;

  assign in_req    = req_t'(in_tuser);
  assign in_id     = in_tdata[4:0];
  assign in_now    = in_tdata[52:5];
  assign in_delay  = in_tdata[84:53];
  assign in_period = in_tdata[116:85];
  assign in_catch  = in_tdata[117];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign out_free = !out_v_r || out_tready;
  assign can_push = !hold_v_r || out_free;
  assign move     = hold_v_r && out_free && (push || state_r == S_FLUSH);

  assign c_w       = {1'b0, k_r} << 1;
  assign c1_w      = c_w + 1'b1;
  assign ret_state = (op_r == REQ_ADV) ? S_ADV_RD : S_FLUSH;
  assign again     = seen_r[top_r.slot];

  tmh_modu u_modu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (pm_rd_r.period),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    ent_nxt    = ent_r;
    top_nxt    = top_r;
    per_nxt    = per_r;
    re         = 1'b0;
    ra_addr    = '0;
    rb_addr    = '0;
    we         = 1'b0;
    waddr      = k_r;
    wdata      = ent_r;
    pm_we      = 1'b0;
    pm_wa      = in_id;
    pm_wd      = '{catch_up: in_catch, period: in_period};
    pm_re      = 1'b0;
    pm_ra      = ra_data_r.slot;
    pos_we     = 1'b0;
    pos_idx    = ent_r.slot;
    pos_val    = k_r;
    seen_clr   = 1'b0;
    seen_set   = 1'b0;
    push       = 1'b0;
    push_id    = in_id;
    push_fired = 1'b0;
    push_st    = ST_OK;
    div_start  = 1'b0;
    div_dvd    = '0;
    use_b      = 1'b0;
    ch         = ra_data_r;
    at1        = '0;
    pad        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt = in_req;
          unique case (in_req)
            REQ_ADV: begin
              cur_nxt   = in_now;
              seen_clr  = 1'b1;
              state_nxt = S_ADV_RD;
            end
            REQ_START: begin
              push = 1'b1;
              if (pos_r[in_id] != '0 || cnt_r >= CNT_W'(NUM_TIMERS)) begin
                push_st   = ST_REFUSED;
                state_nxt = S_FLUSH;
              end else begin
                pm_we     = 1'b1;
                ent_nxt   = '{exp: sat_add(cur_r, TIME_W'(in_delay)), slot: in_id};
                cnt_nxt   = cnt_r + 1'b1;
                k_nxt     = HEAP_AW'(cnt_r + 1'b1);
                state_nxt = S_SU_RD;
              end
            end
            REQ_STOP: begin
              push = 1'b1;
              if (pos_r[in_id] == '0) begin
                push_st   = ST_IGNORED;
                state_nxt = S_FLUSH;
              end else begin
                pos_we    = 1'b1;
                pos_idx   = in_id;
                pos_val   = '0;
                cnt_nxt   = cnt_r - 1'b1;
                k_nxt     = pos_r[in_id];
                state_nxt = (pos_r[in_id] <= HEAP_AW'(cnt_r - 1'b1)) ? S_STP_RD : S_FLUSH;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_STP_RD: begin
        re        = 1'b1;
        ra_addr   = HEAP_AW'(cnt_r + 1'b1);
        rb_addr   = k_r >> 1;
        state_nxt = S_STP_CMP;
      end
      S_STP_CMP: begin
        ent_nxt = ra_data_r;
        if (k_r > HEAP_AW'(1) && ra_data_r.exp <= rb_data_r.exp) begin
          state_nxt = S_SU_RD;
        end else begin
          state_nxt = S_SD_RD;
        end
      end
      S_SU_RD: begin
        if (k_r == HEAP_AW'(1)) begin
          we        = 1'b1;
          pos_we    = 1'b1;
          state_nxt = ret_state;
        end else begin
          re        = 1'b1;
          ra_addr   = k_r >> 1;
          state_nxt = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        if (ra_data_r.exp <= ent_r.exp) begin
          we        = 1'b1;
          pos_we    = 1'b1;
          state_nxt = ret_state;
        end else begin
          we        = 1'b1;
          wdata     = ra_data_r;
          pos_we    = 1'b1;
          pos_idx   = ra_data_r.slot;
          k_nxt     = k_r >> 1;
          state_nxt = S_SU_RD;
        end
      end
      S_SD_RD: begin
        if (c_w > {1'b0, cnt_r}) begin
          we        = 1'b1;
          pos_we    = 1'b1;
          state_nxt = ret_state;
        end else begin
          re        = 1'b1;
          ra_addr   = c_w[HEAP_AW-1:0];
          rb_addr   = (c1_w <= {1'b0, cnt_r}) ? c1_w[HEAP_AW-1:0] : c_w[HEAP_AW-1:0];
          state_nxt = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        use_b = (c1_w <= {1'b0, cnt_r}) && (ra_data_r.exp > rb_data_r.exp);
        ch    = use_b ? rb_data_r : ra_data_r;
        if (ent_r.exp <= ch.exp) begin
          we        = 1'b1;
          pos_we    = 1'b1;
          state_nxt = ret_state;
        end else begin
          we        = 1'b1;
          wdata     = ch;
          pos_we    = 1'b1;
          pos_idx   = ch.slot;
          k_nxt     = use_b ? c1_w[HEAP_AW-1:0] : c_w[HEAP_AW-1:0];
          state_nxt = S_SD_RD;
        end
      end
      S_ADV_RD: begin
        if (cnt_r == '0) begin
          state_nxt = S_FLUSH;
        end else begin
          re        = 1'b1;
          ra_addr   = HEAP_AW'(1);
          rb_addr   = HEAP_AW'(cnt_r);
          state_nxt = S_ADV_SLOT;
        end
      end
      S_ADV_SLOT: begin
        top_nxt = ra_data_r;
        if (ra_data_r.exp < cur_r) begin
          pm_re     = 1'b1;
          state_nxt = S_ADV_EVAL;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_ADV_EVAL: begin
        at1 = again ? top_r.exp : sat_add(top_r.exp, TIME_W'(pm_rd_r.period));
        if (again || can_push) begin
          seen_set   = 1'b1;
          push       = !again;
          push_id    = top_r.slot;
          push_fired = 1'b1;
          if (pm_rd_r.period != '0) begin
            if (at1 < cur_r && (pm_rd_r.catch_up || again)) begin
              div_start = 1'b1;
              div_dvd   = cur_r - at1;
              per_nxt   = pm_rd_r.period;
              state_nxt = S_ADV_DIV;
            end else begin
              ent_nxt   = '{exp: at1, slot: top_r.slot};
              k_nxt     = HEAP_AW'(1);
              state_nxt = S_SD_RD;
            end
          end else begin
            cnt_nxt = cnt_r - 1'b1;
            pos_we  = 1'b1;
            pos_idx = top_r.slot;
            pos_val = '0;
            if (cnt_r > CNT_W'(1)) begin
              ent_nxt   = rb_data_r;
              k_nxt     = HEAP_AW'(1);
              state_nxt = S_SD_RD;
            end else begin
              state_nxt = S_ADV_RD;
            end
          end
        end
      end
      S_ADV_DIV: begin
        if (div_done) begin
          pad       = (div_rem != '0) ? TIME_W'(per_r - div_rem) : '0;
          ent_nxt   = '{exp: sat_add(cur_r, pad), slot: top_r.slot};
          k_nxt     = HEAP_AW'(1);
          state_nxt = S_SD_RD;
        end
      end
      S_FLUSH: begin
        if (!hold_v_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      op_r     <= REQ_NONE;
      cur_r    <= '0;
      cnt_r    <= '0;
      seen_r   <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      if (seen_clr) begin
        seen_r <= '0;
      end else if (seen_set) begin
        seen_r[top_r.slot] <= 1'b1;
      end
      if (pos_we) begin
        pos_r[pos_idx] <= pos_val;
      end
      if (push) begin
        hold_v_r <= 1'b1;
      end else if (move) begin
        hold_v_r <= 1'b0;
      end
      if (out_free) begin
        out_v_r <= move;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    ent_r <= ent_nxt;
    top_r <= top_nxt;
    per_r <= per_nxt;
    if (push) begin
      hold_id_r    <= push_id;
      hold_fired_r <= push_fired;
      hold_st_r    <= push_st;
    end
    if (move) begin
      out_id_r    <= hold_id_r;
      out_fired_r <= hold_fired_r;
      out_st_r    <= hold_st_r;
      out_last_r  <= (state_r == S_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    if (re) begin
      ra_data_r <= heap_mem[ra_addr];
      rb_data_r <= heap_mem[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_wa] <= pm_wd;
    end
    if (pm_re) begin
      pm_rd_r <= pm_mem[pm_ra];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_st_r, out_id_r};
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;
endmodule
`default_nettype wire

[hdl/tmh_modu.sv]
// Bit-serial remainder unit: one dividend bit per cycle.
// Depends on tmh_pkg.
`default_nettype none
module tmh_modu
  import tmh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [PER_W-1:0]  divisor,
  output logic                   done,
  output logic [PER_W-1:0]       rem
);
  localparam int BC_W = $clog2(TIME_W);

  logic              busy_r;
  logic              done_r;
  logic [BC_W-1:0]   bit_r;
  logic [TIME_W-1:0] dv_r;
  logic [PER_W-1:0]  dvs_r;
  logic [PER_W-1:0]  rem_r;
  logic [PER_W:0]    trial;

  assign trial = {rem_r, dv_r[TIME_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= BC_W'(TIME_W - 1);
        dv_r   <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_r <= PER_W'(trial - {1'b0, dvs_r});
        end else begin
          rem_r <= trial[PER_W-1:0];
        end
        dv_r <= dv_r << 1;
        if (bit_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          bit_r <= bit_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

[hdl/tmh_checker.sv]
// Port-level checks for the timer heap scheduler, bound to the top level.
// Depends on tmh_pkg and timer_min_heap_scheduler.
`default_nettype none
module tmh_checker
  import tmh_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [7:0]   out_tdata,
  input wire logic         out_tuser,
  input wire logic         out_tlast
);
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[6:5] == ST_OK && out_tdata[7] == 1'b0)
    else $error("expiry beat with nonzero status");

  a_ctrl_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("start or stop reply not marked last");
endmodule

bind timer_min_heap_scheduler tmh_checker u_tmh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
